@@ sv/assert_macros.svh @@
// ============================================================================
// Assertion macros
// Shorthand for the concurrent assertions of the formatter's checker.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PIFU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed in %m");

// The consequent must hold in the cycle after the antecedent.
`define PIFU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed in %m");

// The consequent must hold in the cycle after reset is seen asserted.
`define PIFU_ASSERT_AFTER_RESET(lbl, clk, rst_n, cons) \
    lbl: assert property (@(posedge clk) !(rst_n) |=> (cons)) \
        else $error("assertion failed in %m");

`endif

@@ sv/pifu_pkg.sv @@
// ============================================================================
// pifu_pkg
// Types, character codes and helpers shared by the integer formatter.
// ============================================================================
package pifu_pkg;

    // Default values of the top level parameters.
    localparam int MAX_WIDTH_DEF    = 64;
    localparam int DIGIT_BUFFER_DEF = 22;

    // Width of the magnitude field.
    localparam int MAG_W = 64;

    // Radix select codes.
    typedef enum logic [1:0] {
        FN_DEC    = 2'd0,
        FN_OCT    = 2'd1,
        FN_HEX_LO = 2'd2,
        FN_HEX_UP = 2'd3
    } t_func;

    typedef logic [6:0] t_width;
    typedef logic [5:0] t_prec;

    // ASCII codes used by the sequencer.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_X  = 8'h78;

    // One input item.
    typedef struct packed {
        t_func             func;
        logic [MAG_W-1:0]  magnitude;
        logic              negative;
        t_width            field_width;
        logic              has_precision;
        t_prec             precision;
        logic              zero_flag;
        logic              left_flag;
        logic              alt_flag;
        logic              plus_flag;
        logic              space_flag;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
    } t_out_item;

    // Conversion settings held while an item is in work, already saturated.
    typedef struct packed {
        t_func  func;
        logic   negative;
        t_width width;
        logic   has_prec;
        t_prec  prec;
        logic   zero_flag;
        logic   left_flag;
        logic   alt_flag;
        logic   plus_flag;
        logic   space_flag;
    } t_fmt;

    // Requests to the digit converter.
    typedef struct packed {
        logic start;
        logic pop;
    } t_conv_ctl;

    // Status from the digit converter.
    typedef struct packed {
        logic       done;
        logic [3:0] top_digit;
    } t_conv_sts;

    // Map a digit value to its ASCII character, hex letters in either case.
    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        if (d < 4'd10) begin
            base = CH_ZERO;
        end else if (upper) begin
            base = CH_UP_A - 8'd10;
        end else begin
            base = CH_LO_A - 8'd10;
        end
        return base + {4'b0000, d};
    endfunction

endpackage

@@ sv/pifu_if.sv @@
// ============================================================================
// pifu_if
// Valid/ready channels of the integer formatter: one for input items and
// one for result items.
// ============================================================================

// Input channel: number and conversion settings.
interface pifu_in_if
    import pifu_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// Output channel: one character per item.
interface pifu_out_if
    import pifu_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ sv/printf_integer_formatter_unit.sv @@
// ============================================================================
// printf_integer_formatter_unit
// Formats one 64-bit magnitude with a sign flag as decimal, octal or hex text
// under printf rules for width, precision and the 0, -, #, + and space flags.
// Input channel i_in takes one number with its settings per item; output
// channel o_out gives one ASCII character per item, last set on the final
// one. A number that formats to no text (zero at precision zero) gives no
// output item at all.
// The converter takes one magnitude bit per cycle, then strips the leading
// zero digits, up to DIGIT_BUFFER of them, before the sequencer lays out
// the field. One item is in work at a time; i_in.ready drops on acceptance
// and rises again only after the last character is loaded and the
// sequencer has finished. Reset clears the sequencers; i_in.ready is high
// and o_out.valid low in the next cycle. When the receiver stalls, the
// character waiting in the output register holds and the sequencer waits
// for it.
// ============================================================================
module printf_integer_formatter_unit
    import pifu_pkg::*;
#(
    parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
    parameter int DIGIT_BUFFER = DIGIT_BUFFER_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pifu_in_if.sink    i_in,
    pifu_out_if.source o_out
);

    localparam int     NDW       = $clog2(DIGIT_BUFFER + 1);
    localparam t_width WIDTH_CAP = t_width'(MAX_WIDTH);
    localparam t_prec  PREC_CAP  = t_prec'(MAX_WIDTH - 4);

    logic           r_busy;
    t_fmt           r_fmt;
    t_fmt           w_fmt;
    logic           w_accept;
    t_conv_ctl      w_ctl;
    t_conv_sts      w_sts;
    logic [NDW-1:0] w_nd;
    logic           w_pop;
    logic           w_fin;

    assign i_in.ready = !r_busy;
    assign w_accept   = i_in.valid && !r_busy;

    // Saturate width and precision; no precision counts as zero.
    always_comb begin
        w_fmt.func       = i_in.data.func;
        w_fmt.negative   = i_in.data.negative;
        w_fmt.width      = (i_in.data.field_width > WIDTH_CAP) ? WIDTH_CAP
                                                               : i_in.data.field_width;
        w_fmt.has_prec   = i_in.data.has_precision;
        w_fmt.prec       = !i_in.data.has_precision ? '0
                         : ((i_in.data.precision > PREC_CAP) ? PREC_CAP
                                                             : i_in.data.precision);
        w_fmt.zero_flag  = i_in.data.zero_flag;
        w_fmt.left_flag  = i_in.data.left_flag;
        w_fmt.alt_flag   = i_in.data.alt_flag;
        w_fmt.plus_flag  = i_in.data.plus_flag;
        w_fmt.space_flag = i_in.data.space_flag;
    end

    // Hold the settings from acceptance until the sequencer finishes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_accept) begin
            r_busy <= 1'b1;
            r_fmt  <= w_fmt;
        end else if (w_fin) begin
            r_busy <= 1'b0;
        end
    end

    assign w_ctl = '{start: w_accept, pop: w_pop};

    pifu_conv #(
        .DIGIT_BUFFER (DIGIT_BUFFER)
    ) u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_mag   (i_in.data.magnitude),
        .i_radix (i_in.data.func),
        .o_sts   (w_sts),
        .o_nd    (w_nd)
    );

    pifu_emit #(
        .MAX_WIDTH    (MAX_WIDTH),
        .DIGIT_BUFFER (DIGIT_BUFFER)
    ) u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fmt   (r_fmt),
        .i_sts   (w_sts),
        .i_nd    (w_nd),
        .o_pop   (w_pop),
        .o_fin   (w_fin),
        .o_out   (o_out)
    );

endmodule

@@ sv/pifu_conv.sv @@
// ============================================================================
// pifu_conv
// Bit-serial radix converter. The magnitude is shifted in one bit per cycle,
// MSB first, into a chain of 4-bit digit cells (add-3 correction for decimal,
// 3-bit cells for octal, plain 4-bit cells for hex). Leading zero digits are
// then shifted out one per cycle, and the digits are popped MSB first.
// ============================================================================
module pifu_conv
    import pifu_pkg::*;
#(
    parameter int DIGIT_BUFFER = DIGIT_BUFFER_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  t_conv_ctl                           i_ctl,
    input  logic [MAG_W-1:0]                    i_mag,
    input  t_func                               i_radix,
    output t_conv_sts                           o_sts,
    output logic [$clog2(DIGIT_BUFFER+1)-1:0]   o_nd
);

    localparam int NDW = $clog2(DIGIT_BUFFER + 1);
    localparam int BCW = $clog2(MAG_W);

    typedef enum logic [1:0] {
        C_IDLE,
        C_CONV,
        C_NORM
    } t_state;

    t_state                         r_state;
    logic                           r_done;
    logic [MAG_W-1:0]               r_mag;
    t_func                          r_radix;
    logic [DIGIT_BUFFER-1:0][3:0]   r_dig;
    logic [BCW-1:0]                 r_bits;
    logic [NDW-1:0]                 r_lz;

    logic [DIGIT_BUFFER-1:0][3:0]   w_adj;
    logic [DIGIT_BUFFER-1:0][3:0]   w_step;
    logic [DIGIT_BUFFER-1:0][3:0]   w_up;
    logic [DIGIT_BUFFER-1:0]        w_cout;
    logic [DIGIT_BUFFER-1:0]        w_cin;
    logic                           w_norm_shift;

    // Per-cell correction and the bit each cell passes to the next one up.
    always_comb begin
        for (int i = 0; i < DIGIT_BUFFER; i++) begin
            unique case (r_radix) inside
                FN_DEC: begin
                    w_adj[i]  = (r_dig[i] >= 4'd5) ? r_dig[i] + 4'd3 : r_dig[i];
                    w_cout[i] = w_adj[i][3];
                end
                FN_OCT: begin
                    w_adj[i]  = r_dig[i];
                    w_cout[i] = r_dig[i][2];
                end
                FN_HEX_LO, FN_HEX_UP: begin
                    w_adj[i]  = r_dig[i];
                    w_cout[i] = r_dig[i][3];
                end
            endcase
        end
    end

    // The lowest cell takes the next magnitude bit.
    assign w_cin = {w_cout[DIGIT_BUFFER-2:0], r_mag[MAG_W-1]};

    // New cell values for one conversion step.
    always_comb begin
        for (int i = 0; i < DIGIT_BUFFER; i++) begin
            if (r_radix == FN_OCT) begin
                w_step[i] = {1'b0, w_adj[i][1:0], w_cin[i]};
            end else begin
                w_step[i] = {w_adj[i][2:0], w_cin[i]};
            end
        end
    end

    // Whole-digit shift toward the top cell.
    assign w_up = {r_dig[DIGIT_BUFFER-2:0], 4'd0};

    // A leading zero digit is still to be stripped.
    assign w_norm_shift = (r_dig[DIGIT_BUFFER-1] == 4'd0) && (r_lz != NDW'(DIGIT_BUFFER));

    // Sequencer: convert, strip leading zeros, then pop digits on request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == C_NORM) && !w_norm_shift;
            unique case (r_state)
                C_IDLE: begin
                    if (i_ctl.start) begin
                        r_state <= C_CONV;
                        r_mag   <= i_mag;
                        r_radix <= i_radix;
                        r_dig   <= '0;
                        r_bits  <= '0;
                        r_lz    <= '0;
                    end else if (i_ctl.pop) begin
                        r_dig <= w_up;
                    end
                end
                C_CONV: begin
                    r_dig  <= w_step;
                    r_mag  <= {r_mag[MAG_W-2:0], 1'b0};
                    r_bits <= r_bits + 1'b1;
                    if (r_bits == BCW'(MAG_W - 1)) begin
                        r_state <= C_NORM;
                    end
                end
                C_NORM: begin
                    if (w_norm_shift) begin
                        r_dig <= w_up;
                        r_lz  <= r_lz + 1'b1;
                    end else begin
                        r_state <= C_IDLE;
                    end
                end
                default: begin
                    r_state <= C_IDLE;
                end
            endcase
        end
    end

    assign o_sts = '{done: r_done, top_digit: r_dig[DIGIT_BUFFER-1]};
    assign o_nd  = NDW'(DIGIT_BUFFER) - r_lz;

endmodule

@@ sv/pifu_emit.sv @@
// ============================================================================
// pifu_emit
// Field layout and character sequencer. Works out sign, prefix, precision fill
// and padding, then walks the segments of the field; within a segment it loads
// one character per cycle into the output register while the receiver keeps up.
// ============================================================================
module pifu_emit
    import pifu_pkg::*;
#(
    parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
    parameter int DIGIT_BUFFER = DIGIT_BUFFER_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  t_fmt                                i_fmt,
    input  t_conv_sts                           i_sts,
    input  logic [$clog2(DIGIT_BUFFER+1)-1:0]   i_nd,
    output logic                                o_pop,
    output logic                                o_fin,
    pifu_out_if.source                          o_out
);

    localparam int LW = $clog2(MAX_WIDTH + DIGIT_BUFFER + 4);

    typedef enum logic [2:0] {
        E_IDLE,
        E_DPAD,
        E_BODY,
        E_PAD,
        E_RUN
    } t_state;

    typedef enum logic [3:0] {
        SG_START,
        SG_LPAD,
        SG_SIGN,
        SG_ALT0,
        SG_ALTX,
        SG_ZPAD,
        SG_PREC,
        SG_DIGS,
        SG_TPAD
    } t_seg;

    t_state         r_state;
    t_seg           r_seg;
    logic [LW-1:0]  r_cnt;
    logic [LW-1:0]  r_left;
    logic [LW-1:0]  r_nd;
    logic [LW-1:0]  r_dpad;
    logic [LW-1:0]  r_body;
    logic [LW-1:0]  r_pad;
    logic           r_mzero;
    logic           r_sign_len;
    logic [7:0]     r_sign_char;
    logic           r_zero_pad;
    logic [1:0]     r_alt;
    logic           r_out_valid;
    logic [7:0]     r_out_char;
    logic           r_out_last;
    logic           r_fin;

    logic [LW-1:0]  w_prec;
    logic [LW-1:0]  w_width;
    logic [LW-1:0]  w_nd_eff;
    logic [LW-1:0]  w_dpad;
    logic [1:0]     w_alt;
    t_seg           w_seg_next;
    logic [LW-1:0]  w_len_next;
    logic [7:0]     w_char;
    logic           w_emit;

    assign w_prec  = LW'(i_fmt.prec);
    assign w_width = LW'(i_fmt.width);

    // A zero value has one digit, or none when the precision is an explicit zero.
    assign w_nd_eff = (i_nd == '0)
                    ? ((i_fmt.has_prec && i_fmt.prec == '0) ? '0 : LW'(1))
                    : LW'(i_nd);

    // Precision fill and the alternate-form prefix length.
    assign w_dpad = (w_prec > r_nd) ? w_prec - r_nd : '0;

    always_comb begin
        w_alt = 2'd0;
        if (i_fmt.alt_flag) begin
            unique case (i_fmt.func) inside
                FN_HEX_LO, FN_HEX_UP: w_alt = r_mzero ? 2'd0 : 2'd2;
                FN_OCT: begin
                    // The extra 0 only when the digits do not already start with 0.
                    if (w_prec <= r_nd && (!r_mzero || r_nd == '0)) begin
                        w_alt = 2'd1;
                    end
                end
                FN_DEC: w_alt = 2'd0;
            endcase
        end
    end

    // Next segment of the field and its length.
    always_comb begin
        w_seg_next = SG_TPAD;
        w_len_next = '0;
        unique case (r_seg)
            SG_START: begin
                w_seg_next = SG_LPAD;
                w_len_next = (!i_fmt.left_flag && !r_zero_pad) ? r_pad : '0;
            end
            SG_LPAD: begin
                w_seg_next = SG_SIGN;
                w_len_next = LW'(r_sign_len);
            end
            SG_SIGN: begin
                w_seg_next = SG_ALT0;
                w_len_next = LW'(r_alt != 2'd0);
            end
            SG_ALT0: begin
                w_seg_next = SG_ALTX;
                w_len_next = LW'(r_alt == 2'd2);
            end
            SG_ALTX: begin
                w_seg_next = SG_ZPAD;
                w_len_next = r_zero_pad ? r_pad : '0;
            end
            SG_ZPAD: begin
                w_seg_next = SG_PREC;
                w_len_next = r_dpad;
            end
            SG_PREC: begin
                w_seg_next = SG_DIGS;
                w_len_next = r_nd;
            end
            SG_DIGS: begin
                w_seg_next = SG_TPAD;
                w_len_next = i_fmt.left_flag ? r_pad : '0;
            end
            SG_TPAD: begin
                w_seg_next = SG_TPAD;
                w_len_next = '0;
            end
            default: begin
                w_seg_next = SG_TPAD;
                w_len_next = '0;
            end
        endcase
    end

    // Character of the current segment.
    always_comb begin
        unique case (r_seg) inside
            SG_SIGN:                   w_char = r_sign_char;
            SG_ALT0, SG_ZPAD, SG_PREC: w_char = CH_ZERO;
            SG_ALTX: w_char = (i_fmt.func == FN_HEX_UP) ? CH_UP_X : CH_LO_X;
            SG_DIGS: w_char = digit_char(i_sts.top_digit, i_fmt.func == FN_HEX_UP);
            default:                   w_char = CH_SPACE;
        endcase
    end

    // A character goes out when the segment has one left and the register is free.
    assign w_emit = (r_state == E_RUN) && (r_cnt != '0) && (!r_out_valid || o_out.ready);
    assign o_pop  = w_emit && (r_seg == SG_DIGS);

    // Layout steps, segment walk and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= E_IDLE;
            r_out_valid <= 1'b0;
            r_fin       <= 1'b0;
        end else begin
            r_fin <= (r_state == E_RUN) && (r_cnt == '0) && (r_seg == SG_TPAD);
            if (w_emit) begin
                r_out_valid <= 1'b1;
                r_out_char  <= w_char;
                r_out_last  <= (r_left == LW'(1));
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                E_IDLE: begin
                    if (i_sts.done) begin
                        r_mzero     <= (i_nd == '0);
                        r_nd        <= w_nd_eff;
                        r_sign_len  <= i_fmt.negative || i_fmt.plus_flag || i_fmt.space_flag;
                        r_sign_char <= i_fmt.negative ? CH_MINUS
                                     : (i_fmt.plus_flag ? CH_PLUS : CH_SPACE);
                        r_zero_pad  <= i_fmt.zero_flag && !i_fmt.has_prec && !i_fmt.left_flag;
                        r_state     <= E_DPAD;
                    end
                end
                E_DPAD: begin
                    r_dpad  <= w_dpad;
                    r_alt   <= w_alt;
                    r_state <= E_BODY;
                end
                E_BODY: begin
                    r_body  <= LW'(r_sign_len) + LW'(r_alt) + r_dpad + r_nd;
                    r_state <= E_PAD;
                end
                E_PAD: begin
                    r_pad   <= (w_width > r_body) ? w_width - r_body : '0;
                    r_left  <= (w_width > r_body) ? w_width : r_body;
                    r_seg   <= SG_START;
                    r_cnt   <= '0;
                    r_state <= E_RUN;
                end
                E_RUN: begin
                    if (r_cnt == '0) begin
                        if (r_seg == SG_TPAD) begin
                            r_state <= E_IDLE;
                        end else begin
                            r_seg <= w_seg_next;
                            r_cnt <= w_len_next;
                        end
                    end else if (w_emit) begin
                        r_cnt  <= r_cnt - 1'b1;
                        r_left <= r_left - 1'b1;
                    end
                end
                default: begin
                    r_state <= E_IDLE;
                end
            endcase
        end
    end

    assign o_fin       = r_fin;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = t_out_item'{out_char: r_out_char, last: r_out_last};

endmodule

@@ sv/pifu_checker.sv @@
// ============================================================================
// pifu_checker
// Port-level checks of the integer formatter, bound to the top level.
// ============================================================================
`include "assert_macros.svh"

module pifu_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_char,
    input logic       i_out_last
);

    // A stalled character stays offered and unchanged.
    `PIFU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `PIFU_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_char) && $stable(i_out_last))

    // One number in work at a time: acceptance closes the input.
    `PIFU_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // New characters only appear while a number is in work.
    `PIFU_ASSERT_NOW(a_emit_busy, i_clk, i_rst_n, $rose(i_out_valid), !i_in_ready)

    // Reset leaves the block open for input with nothing to send.
    `PIFU_ASSERT_AFTER_RESET(a_reset_state, i_clk, i_rst_n, i_in_ready && !i_out_valid)

endmodule

bind printf_integer_formatter_unit pifu_checker u_pifu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_char  (o_out.data.out_char),
    .i_out_last  (o_out.data.last)
);

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Integer formatter testbench
// Feeds numbers with printf conversion settings into the formatter, predicts
// the text each one should produce, and checks every character and its last
// marker against that prediction while both channels stall at random.
// ----------------------------------------------------------------------------
module testbench;
    import pifu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk;
    logic i_rst_n;

    pifu_in_if  in_ch ();
    pifu_out_if out_ch ();

    printf_integer_formatter_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Numbers still to be offered and characters still to arrive.
    t_in_item  waiting_numbers[$];
    t_out_item expected_chars[$];

    int   n_bad;
    int   n_taken;
    logic in_taken;
    logic calm;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Generous ceiling on the run time.
    initial begin
        #5ms;
        $display("[printf_integer_formatter_unit] ERROR");
        $finish;
    end

    // A stretch of items in the middle runs with no idling on either side.
    assign calm = (n_taken >= 90) && (n_taken < 150);

    // Build one input item from its fields.
    function automatic t_in_item make_number(input t_func fn, input logic [63:0] mag,
                                             input logic neg, input int wid,
                                             input logic hp, input int prc,
                                             input logic zf, input logic lf,
                                             input logic af, input logic pf,
                                             input logic sf);
        t_in_item it;
        it.func          = fn;
        it.magnitude     = mag;
        it.negative      = neg;
        it.field_width   = t_width'(wid);
        it.has_precision = hp;
        it.precision     = t_prec'(prc);
        it.zero_flag     = zf;
        it.left_flag     = lf;
        it.alt_flag      = af;
        it.plus_flag     = pf;
        it.space_flag    = sf;
        return it;
    endfunction

    // Work out the formatted text of one number and queue its characters.
    function automatic void format_text(input t_in_item it);
        logic [63:0] v;
        logic [63:0] radix;
        logic [3:0]  d;
        logic [7:0]  rev[DIGIT_BUFFER_DEF];
        logic [7:0]  txt[$];
        logic [7:0]  sgn;
        logic        zpad;
        logic        upper;
        t_out_item   oi;
        int          nd;
        int          wid;
        int          prc;
        int          dpad;
        int          alt;
        int          body;
        int          pad;
        int          len;
        int          i;

        nd    = 0;
        alt   = 0;
        upper = (it.func == FN_HEX_UP);
        radix = (it.func == FN_DEC) ? 64'd10 : ((it.func == FN_OCT) ? 64'd8 : 64'd16);
        wid   = (int'(it.field_width) > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(it.field_width);
        if (!it.has_precision) begin
            prc = 0;
        end else begin
            prc = (int'(it.precision) > MAX_WIDTH_DEF - 4) ? MAX_WIDTH_DEF - 4
                                                          : int'(it.precision);
        end

        // Digits, least significant first; zero at precision zero has none.
        v = it.magnitude;
        if (v == 64'd0) begin
            if (!(it.has_precision && prc == 0)) begin
                rev[nd] = CH_ZERO;
                nd++;
            end
        end else begin
            while (v != 64'd0 && nd < DIGIT_BUFFER_DEF) begin
                d = 4'(v % radix);
                if (d < 4'd10) begin
                    rev[nd] = CH_ZERO + {4'd0, d};
                end else if (upper) begin
                    rev[nd] = CH_UP_A + {4'd0, d} - 8'd10;
                end else begin
                    rev[nd] = CH_LO_A + {4'd0, d} - 8'd10;
                end
                nd++;
                v = v / radix;
            end
        end

        zpad = it.zero_flag && !it.has_precision && !it.left_flag;
        if (it.negative) begin
            sgn = CH_MINUS;
        end else if (it.plus_flag) begin
            sgn = CH_PLUS;
        end else if (it.space_flag) begin
            sgn = CH_SPACE;
        end else begin
            sgn = 8'd0;
        end

        // The octal leading zero is only added when no zero leads already.
        dpad = (prc > nd) ? prc - nd : 0;
        if (it.alt_flag) begin
            if (radix == 64'd16 && it.magnitude != 64'd0) begin
                alt = 2;
            end else if (radix == 64'd8 && dpad == 0 && (nd == 0 || rev[nd-1] != CH_ZERO)) begin
                alt = 1;
            end
        end

        body = ((sgn != 8'd0) ? 1 : 0) + alt + dpad + nd;
        pad  = (wid > body) ? wid - body : 0;

        if (!it.left_flag && !zpad) begin
            for (i = 0; i < pad; i++) txt.push_back(CH_SPACE);
        end
        if (sgn != 8'd0) txt.push_back(sgn);
        if (alt >= 1) txt.push_back(CH_ZERO);
        if (alt == 2) txt.push_back(upper ? CH_UP_X : CH_LO_X);
        if (zpad) begin
            for (i = 0; i < pad; i++) txt.push_back(CH_ZERO);
        end
        for (i = 0; i < dpad; i++) txt.push_back(CH_ZERO);
        for (i = nd; i > 0; i--) txt.push_back(rev[i-1]);
        if (it.left_flag) begin
            for (i = 0; i < pad; i++) txt.push_back(CH_SPACE);
        end

        // The text never runs past the output cap.
        len = (txt.size() > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : txt.size();
        for (i = 0; i < len; i++) begin
            oi.out_char = txt[i];
            oi.last     = (i + 1 == len);
            expected_chars.push_back(oi);
        end
    endfunction

    // Driver: offer the next number and set the receiver's ready at the falling edge.
    always @(negedge i_clk) begin : drive
        logic     nv;
        t_in_item nd;
        nv = in_ch.valid;
        nd = in_ch.data;
        if (!i_rst_n) begin
            nv = 1'b0;
        end else begin
            if (in_ch.valid && in_taken) begin
                nv = 1'b0;
            end
            if (!nv && waiting_numbers.size() > 0 && (calm || $urandom_range(99) >= 23)) begin
                nd = waiting_numbers.pop_front();
                nv = 1'b1;
            end
        end
        in_ch.valid  <= nv;
        in_ch.data   <= nd;
        out_ch.ready <= calm || ($urandom_range(99) >= 23);
    end

    // Monitor: predict on each accepted number, check each accepted character.
    always @(posedge i_clk) begin : observe
        t_out_item want;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                format_text(in_ch.data);
                n_taken <= n_taken + 1;
            end
            if (out_ch.valid && out_ch.ready) begin
                if (expected_chars.size() == 0) begin
                    $display("%0t: unexpected character: expected none, got %h last %b",
                             $realtime, out_ch.data.out_char, out_ch.data.last);
                    n_bad++;
                end else begin
                    want = expected_chars.pop_front();
                    if (out_ch.data.out_char !== want.out_char) begin
                        $display("%0t: character mismatch: expected %h, got %h",
                                 $realtime, want.out_char, out_ch.data.out_char);
                        n_bad++;
                    end
                    if (out_ch.data.last !== want.last) begin
                        $display("%0t: last mismatch: expected %b, got %b",
                                 $realtime, want.last, out_ch.data.last);
                        n_bad++;
                    end
                end
            end
        end
        in_taken <= i_rst_n && in_ch.valid && in_ch.ready;
    end

    // Stimulus and end of run.
    initial begin : stimulus
        logic [63:0] mag;
        int          wid;
        int          k;
        logic [63:0] all_ones;

        all_ones     = '1;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        in_taken     = 1'b0;
        n_bad        = 0;
        n_taken      = 0;
        i_rst_n      = 1'b0;

        // Directed numbers: extremes of every field and each corner rule.
        // Plain zero in decimal.
        waiting_numbers.push_back(make_number(FN_DEC, 64'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // Zero at precision zero gives no text at all.
        waiting_numbers.push_back(make_number(FN_DEC, 64'd0, 0, 0, 1, 0, 0, 0, 0, 0, 0));
        // Zero at precision zero, octal alternate form still gives one zero.
        waiting_numbers.push_back(make_number(FN_OCT, 64'd0, 0, 0, 1, 0, 0, 0, 1, 0, 0));
        // Zero at precision zero with a width: padding only.
        waiting_numbers.push_back(make_number(FN_DEC, 64'd0, 0, 5, 1, 0, 0, 0, 0, 0, 0));
        // Largest magnitude in every radix.
        waiting_numbers.push_back(make_number(FN_DEC, all_ones, 1, 0, 0, 0, 0, 0, 0, 0, 0));
        waiting_numbers.push_back(make_number(FN_OCT, all_ones, 0, 0, 0, 0, 0, 0, 1, 0, 0));
        waiting_numbers.push_back(make_number(FN_HEX_LO, all_ones, 0, 127, 0, 0, 1, 0, 1, 0, 0));
        waiting_numbers.push_back(make_number(FN_HEX_UP, all_ones, 0, 40, 0, 0, 0, 1, 1, 0, 0));
        // Sign precedence: plus over space, minus over both.
        waiting_numbers.push_back(make_number(FN_DEC, 64'd42, 0, 0, 0, 0, 0, 0, 0, 1, 1));
        waiting_numbers.push_back(make_number(FN_DEC, 64'd42, 0, 6, 0, 0, 0, 0, 0, 0, 1));
        waiting_numbers.push_back(make_number(FN_DEC, 64'd42, 1, 6, 0, 0, 1, 0, 0, 1, 1));
        // Precision above the cap saturates.
        waiting_numbers.push_back(make_number(FN_HEX_LO, 64'hBEEF, 0, 127, 1, 63, 0, 0, 1, 1, 0));
        // The zero flag is ignored once a precision is given.
        waiting_numbers.push_back(make_number(FN_DEC, 64'd123, 1, 12, 1, 5, 1, 0, 0, 0, 0));
        // Left alignment wins over zero padding.
        waiting_numbers.push_back(make_number(FN_DEC, 64'd77, 0, 10, 0, 0, 1, 1, 0, 0, 1));
        // Octal alternate form where precision already supplies a leading zero.
        waiting_numbers.push_back(make_number(FN_OCT, 64'd8, 0, 0, 1, 5, 0, 0, 1, 0, 0));
        // Hex prefix is dropped for a zero magnitude.
        waiting_numbers.push_back(make_number(FN_HEX_UP, 64'd0, 0, 4, 0, 0, 0, 0, 1, 0, 0));
        // Widths at and above the cap.
        waiting_numbers.push_back(make_number(FN_DEC, 64'd9, 1, 64, 0, 0, 1, 0, 0, 0, 0));
        waiting_numbers.push_back(make_number(FN_OCT, 64'o777, 0, 65, 0, 0, 0, 1, 0, 0, 0));
        // Zero padding after a hex prefix.
        waiting_numbers.push_back(make_number(FN_HEX_LO, 64'h1, 0, 10, 0, 0, 1, 0, 1, 0, 1));
        // Zero with every flag set and precision given.
        waiting_numbers.push_back(make_number(FN_HEX_UP, 64'd0, 0, 127, 1, 63, 1, 1, 1, 1, 1));

        // Random numbers: mostly short widths, magnitudes of every size.
        for (k = 0; k < 200; k++) begin
            case ($urandom_range(4))
                0: mag = 64'd0;
                1: mag = 64'($urandom_range(1000));
                2: mag = {$urandom, $urandom} >> $urandom_range(63);
                default: mag = {$urandom, $urandom};
            endcase
            wid = ($urandom_range(9) < 7) ? $urandom_range(30) : $urandom_range(127);
            waiting_numbers.push_back(make_number(t_func'($urandom_range(3)), mag,
                                                  1'($urandom), wid, 1'($urandom),
                                                  $urandom_range(63), 1'($urandom),
                                                  1'($urandom), 1'($urandom),
                                                  1'($urandom), 1'($urandom)));
        end

        // Hold reset, then release it at a falling edge.
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Wait until every number is taken and every character has come.
        while (waiting_numbers.size() != 0 || in_ch.valid) @(posedge i_clk);
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        if (n_bad == 0 && expected_chars.size() == 0) begin
            $display("[printf_integer_formatter_unit] OK");
        end else begin
            $display("[printf_integer_formatter_unit] ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/pifu_pkg.sv
sv/pifu_if.sv
sv/pifu_conv.sv
sv/pifu_emit.sv
sv/printf_integer_formatter_unit.sv
sv/pifu_checker.sv
tb/testbench.sv
